// File: rtl/hsv2rgba_pkg.sv
// Shared constants, codes and types of the HSV to RGBA color converter.
`default_nettype none

package hsv2rgba_pkg;

	// Field widths of the input and result items.
	localparam int HUE_W   = 15;
	localparam int SV_W    = 9;
	localparam int ALPHA_W = 8;
	localparam int RGBA_W  = 32;
	localparam int BYTE_W  = 8;

	// Default number of fraction bits of saturation, value and the hue fraction.
	localparam int FRAC_BITS_DEF = 8;

	// One 60-degree sector is 3840 hue units, which is 15 * 2^8.
	localparam int SECTOR_UNITS = 3840;
	localparam int SECTOR_SHIFT = 8;
	localparam int SECTOR_ODD   = 15;
	localparam int SECTORS      = 6;
	localparam int REM_W        = $clog2(SECTOR_UNITS);
	localparam int SEC_MAX      = (2**HUE_W - 1) / SECTOR_UNITS;
	localparam int SEC_RAW_W    = $clog2(SEC_MAX + 1);
	localparam int SEC_W        = $clog2(SECTORS);

	// Sector codes, named after the hue range they cover.
	localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
	localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

	// Queue between the front and back parts; the depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QLVL_W-1:0] level;
	} qstat_t;

endpackage

`default_nettype wire

// File: rtl/hsv2rgba_front.sv
// Front part: accepts items, clamps s and v, splits hue into sector and fraction.
`default_nettype none

module hsv2rgba_front import hsv2rgba_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [HUE_W-1:0]     hue,
	input  wire logic [SV_W-1:0]      saturation,
	input  wire logic [SV_W-1:0]      brightness,
	input  wire logic [ALPHA_W-1:0]   alpha_in,
	input  wire qstat_t               q_status,
	output logic                      push,
	output logic [SEC_W+FRAC_BITS+2*(FRAC_BITS+1)+ALPHA_W-1:0] push_data
);

	localparam int ONE_W = FRAC_BITS + 1;
	localparam int CW    = (SV_W > ONE_W) ? SV_W : ONE_W;
	localparam int YW    = FRAC_BITS + 4;
	localparam int K     = FRAC_BITS + 8;
	localparam int MW    = K - 3;
	localparam int PW    = YW + MW;
	localparam longint RECIP_L = ((longint'(1) << K) + SECTOR_ODD - 1) / SECTOR_ODD;
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

	logic                 vld_s1;
	logic [SEC_W-1:0]     sec_s1;
	logic [REM_W-1:0]     rem_s1;
	logic [ONE_W-1:0]     s_s1;
	logic [ONE_W-1:0]     v_s1;
	logic [ALPHA_W-1:0]   alpha_s1;

	logic                 accept;
	logic [SEC_RAW_W-1:0] raw_sec;
	logic [SEC_W-1:0]     sec_mod;
	logic [REM_W-1:0]     rem;
	logic [CW-1:0]        s_ext;
	logic [CW-1:0]        v_ext;
	logic [ONE_W-1:0]     s_clamp;
	logic [ONE_W-1:0]     v_clamp;
	logic [YW-1:0]        y;
	logic [PW-1:0]        prod;
	logic [FRAC_BITS-1:0] f;

	// The queue must hold every item already in flight plus a new one.
	assign busy = ((QLVL_W+1)'(q_status.level) + (QLVL_W+1)'(vld_s1))
		>= (QLVL_W+1)'(QUEUE_DEPTH);
	assign accept = start & ~busy;

	// Sector by a short ladder of constant compares, then hue minus the sector base.
	always_comb begin
		raw_sec = '0;
		for (int k = 1; k <= SEC_MAX; k++) begin
			if (hue >= HUE_W'(k * SECTOR_UNITS)) begin
				raw_sec = SEC_RAW_W'(k);
			end
		end
		rem = REM_W'(hue - HUE_W'(raw_sec * SECTOR_UNITS));
		if (raw_sec >= SEC_RAW_W'(SECTORS)) begin
			sec_mod = SEC_W'(raw_sec - SEC_RAW_W'(SECTORS));
		end else begin
			sec_mod = SEC_W'(raw_sec);
		end
	end

	assign s_ext   = CW'(saturation);
	assign v_ext   = CW'(brightness);
	assign s_clamp = (s_ext > ONE_C) ? ONE_C[ONE_W-1:0] : s_ext[ONE_W-1:0];
	assign v_clamp = (v_ext > ONE_C) ? ONE_C[ONE_W-1:0] : v_ext[ONE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sec_s1   <= sec_mod;
			rem_s1   <= rem;
			s_s1     <= s_clamp;
			v_s1     <= v_clamp;
			alpha_s1 <= alpha_in;
		end
	end

	// f = rem * 2^F / (15 * 2^8): drop or add the power of two, then divide by 15
	// through an exact reciprocal multiply.
	generate
		if (FRAC_BITS >= SECTOR_SHIFT) begin : g_up
			assign y = YW'(rem_s1) << (FRAC_BITS - SECTOR_SHIFT);
		end else begin : g_down
			assign y = YW'(rem_s1 >> (SECTOR_SHIFT - FRAC_BITS));
		end
	endgenerate

	assign prod = PW'(y) * PW'(RECIP);
	assign f    = prod[K +: FRAC_BITS];

	assign push      = vld_s1;
	assign push_data = {sec_s1, f, s_s1, v_s1, alpha_s1};

endmodule

`default_nettype wire

// File: rtl/hsv2rgba_queue.sv
// Short register queue that decouples the front part from the back part.
`default_nettype none

module hsv2rgba_queue import hsv2rgba_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output qstat_t                status
);

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.empty = (level_q == '0);
	assign status.full  = (level_q == QLVL_W'(QUEUE_DEPTH));
	assign status.level = level_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue read while empty");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= QLVL_W'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

endmodule

`default_nettype wire

// File: rtl/hsv2rgba_back.sv
// Back part: forms v, p, q and t, orders them by sector and packs the bytes.
`default_nettype none

module hsv2rgba_back import hsv2rgba_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire qstat_t               q_status,
	output logic                      pop,
	input  wire logic [SEC_W+FRAC_BITS+2*(FRAC_BITS+1)+ALPHA_W-1:0] pop_data,
	output logic                      done,
	output logic [RGBA_W-1:0]         rgba_word
);

	localparam int ONE_W = FRAC_BITS + 1;
	localparam int P2W   = 2 * FRAC_BITS + 1;
	localparam int CW3   = 3 * FRAC_BITS + 1;
	localparam int BW    = CW3 + BYTE_W;
	localparam logic [ONE_W-1:0] ONE    = ONE_W'(1) << FRAC_BITS;
	localparam logic [P2W-1:0]   ONE_SQ = P2W'(1) << (2 * FRAC_BITS);

	function automatic logic [BYTE_W-1:0] to_byte(input logic [CW3-1:0] x);
		logic [BW-1:0] scaled;
		scaled  = (BW'(x) << BYTE_W) - BW'(x);
		return scaled[3*FRAC_BITS +: BYTE_W];
	endfunction

	logic [SEC_W-1:0]     in_sec;
	logic [FRAC_BITS-1:0] in_f;
	logic [ONE_W-1:0]     in_s;
	logic [ONE_W-1:0]     in_v;
	logic [ALPHA_W-1:0]   in_alpha;

	logic                 vld_s1;
	logic [SEC_W-1:0]     sec_s1;
	logic [ONE_W-1:0]     v_s1;
	logic [P2W-1:0]       fs_s1;
	logic [P2W-1:0]       gs_s1;
	logic [P2W-1:0]       vp_s1;
	logic [ALPHA_W-1:0]   alpha_s1;

	logic                 vld_s2;
	logic [SEC_W-1:0]     sec_s2;
	logic [CW3-1:0]       cv_s2;
	logic [CW3-1:0]       cp_s2;
	logic [CW3-1:0]       cq_s2;
	logic [CW3-1:0]       ct_s2;
	logic [ALPHA_W-1:0]   alpha_s2;

	logic [CW3-1:0]       r_c;
	logic [CW3-1:0]       g_c;
	logic [CW3-1:0]       b_c;
	logic                 done_q;
	logic [RGBA_W-1:0]    rgba_q;

	assign {in_sec, in_f, in_s, in_v, in_alpha} = pop_data;

	// The back part never stalls, so it drains the queue whenever it holds an item.
	assign pop = !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Stage 1: f*s, (1-f)*s and v*(1-s).
	always_ff @(posedge clk) begin
		if (pop) begin
			sec_s1   <= in_sec;
			v_s1     <= in_v;
			alpha_s1 <= in_alpha;
			fs_s1    <= P2W'(in_f) * P2W'(in_s);
			gs_s1    <= P2W'(ONE - ONE_W'(in_f)) * P2W'(in_s);
			vp_s1    <= P2W'(in_v) * P2W'(ONE - in_s);
		end
	end

	// Stage 2: all four channels with 3*F fraction bits.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sec_s2   <= sec_s1;
			alpha_s2 <= alpha_s1;
			cv_s2    <= CW3'(v_s1) << (2 * FRAC_BITS);
			cp_s2    <= CW3'(vp_s1) << FRAC_BITS;
			cq_s2    <= CW3'(v_s1) * CW3'(ONE_SQ - fs_s1);
			ct_s2    <= CW3'(v_s1) * CW3'(ONE_SQ - gs_s1);
		end
	end

	always_comb begin
		case (sec_s2)
			SEC_RED_YEL: begin
				r_c = cv_s2; g_c = ct_s2; b_c = cp_s2;
			end
			SEC_YEL_GRN: begin
				r_c = cq_s2; g_c = cv_s2; b_c = cp_s2;
			end
			SEC_GRN_CYN: begin
				r_c = cp_s2; g_c = cv_s2; b_c = ct_s2;
			end
			SEC_CYN_BLU: begin
				r_c = cp_s2; g_c = cq_s2; b_c = cv_s2;
			end
			SEC_BLU_MAG: begin
				r_c = ct_s2; g_c = cp_s2; b_c = cv_s2;
			end
			default: begin
				r_c = cv_s2; g_c = cp_s2; b_c = cq_s2;
			end
		endcase
	end

	// Stage 3: scale by 255, truncate and pack into the output register.
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			rgba_q <= {to_byte(r_c), to_byte(g_c), to_byte(b_c), alpha_s2};
		end
	end

	assign done      = done_q;
	assign rgba_word = rgba_q;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgba_color_core.sv
// Top level of the HSV to RGBA color converter.
//
//   Channel  | Handshake            | Payload ports                            | Dir
//   ---------+----------------------+------------------------------------------+----
//   item in  | start, busy          | hue, saturation, brightness, alpha_in    | in
//   result   | done (one-cycle)     | rgba_word                                | out
//
// An item is taken at a rising edge where start is high and busy is low. Its
// result passes the front register, the queue and the three back stages, then
// goes onto rgba_word with done high and stays for one cycle. One item can
// enter on every clock and one result leaves on every clock; the figure is set
// by the back part, which retires one item per cycle from the queue through its
// three pipeline stages. The asynchronous reset clears all valid bits and the
// queue pointers, so nothing is in flight after reset. The receiver cannot
// stall, so the queue never holds more than one item and busy stays low in
// normal use; busy only guards the queue against overflow.
//
// The front part compares the hue against the sector bases, clamps saturation
// and value to 1.0, and turns the remainder into the fraction f with an exact
// reciprocal multiply. The back part forms v, p, q and t in full precision
// (three times the fraction bits), orders them by sector and scales each by 255.
`default_nettype none

module hsv_to_rgba_color_core import hsv2rgba_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [HUE_W-1:0]   hue,
	input  wire logic [SV_W-1:0]    saturation,
	input  wire logic [SV_W-1:0]    brightness,
	input  wire logic [ALPHA_W-1:0] alpha_in,
	output logic                    done,
	output logic [RGBA_W-1:0]       rgba_word
);

	// Queue entry: sector, fraction f, clamped s and v, alpha.
	localparam int QW = SEC_W + FRAC_BITS + 2 * (FRAC_BITS + 1) + ALPHA_W;

	qstat_t          q_status;
	logic            push;
	logic [QW-1:0]   push_data;
	logic            pop;
	logic [QW-1:0]   pop_data;

	hsv2rgba_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.alpha_in   (alpha_in),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	hsv2rgba_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	hsv2rgba_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop       (pop),
		.pop_data  (pop_data),
		.done      (done),
		.rgba_word (rgba_word)
	);

	// Every accepted item comes out after the fixed latency of the front part, queue and back part.
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted item did not produce a result on time");

endmodule

`default_nettype wire
